>>> hdl/dpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_pkg
// Types, constants and elaboration-time helpers for the dew point pipeline.
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int DIV1_STEPS = 38;   // quotient bits of the Magnus term divide
    localparam int LOG_STEPS  = 32;   // squaring steps of the log2 fraction
    localparam int DIV2_STEPS = 16;   // quotient bits of the dew point divide

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [15:0] SENTINEL_CENTI = -16'sd27300;
    localparam logic signed [42:0] DEN_BASE       = 43'sd75161927680; // 17.5 in Q32

    // register index of the unit select
    localparam logic REG_IDX_FAHR = 1'b0;

    // ln(v) in Q32, same steps as the datapath; constant use only
    function automatic logic [63:0] ln_q32_f(input logic [31:0] v);
        logic [31:0] vv;
        logic [4:0]  e;
        logic [63:0] m;
        logic [31:0] frac;
        vv   = (v == 32'd0) ? 32'd1 : v;
        e    = 5'd0;
        frac = 32'd0;
        for (int i = 0; i < 31; i++) begin
            if ((vv >> (i + 1)) != 32'd0) e = 5'(i + 1);
        end
        if (e <= 5'd30) m = 64'(vv) << (5'd30 - e);
        else            m = 64'(vv) >> 1;
        for (int i = 0; i < 32; i++) begin
            m    = (m * m) >> 30;
            frac = {frac[30:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return 64'(e) * 64'(LN2_Q32) + ((64'(frac) * 64'(LN2_Q32)) >> 32);
    endfunction

    localparam logic [63:0] LN_10000 = ln_q32_f(32'd10000);

    // front section: Magnus term divide and log2 squaring run side by side
    typedef struct packed {
        logic        hzero;
        logic        neg1;
        logic [25:0] d1;
        logic [25:0] r1;
        logic [37:0] nq1;
        logic [3:0]  ex;
        logic [30:0] m;
        logic [31:0] frac;
    } fstage_t;

    // back section: dew point divide
    typedef struct packed {
        logic        hzero;
        logic        ok;
        logic        neg2;
        logic [41:0] d2;
        logic [41:0] r2;
        logic [15:0] nq2;
    } bstage_t;

endpackage
`default_nettype wire

>>> hdl/dew_point_magnus.sv
`default_nettype none
// Throughput: one beat per cycle; the whole pipe advances whenever the
// output register is empty or being drained; a stall halts every stage and the input.
// Most of the depth is in the two restoring dividers (38 + 16 one-bit stages).
// Reset (aresetn low, synchronous) clears all valid bits and the unit select.
// ----------------------------------------------------------------------------
// dew_point_magnus
// Magnus dew point from relative humidity and temperature, fixed point.
// ----------------------------------------------------------------------------
module dew_point_magnus (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB-style config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input beats
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [13:0]        s_humidity_centi,
    input  wire logic signed [14:0] s_temperature_centi,
    // result beats
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_dew_point_centi,
    output logic                    m_dew_point_valid
);
    import dpm_pkg::*;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    logic fahr_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fahr_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_IDX_FAHR) begin
            fahr_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_FAHR) ? {31'd0, fahr_reg} : 32'd0;

    // whole pipe moves together; output register is the last stage
    logic en;
    logic out_vld_reg;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 0: unit conversion, divide set-up, log normalise
    // x = 17502*u / (1000*b), numerator scaled by 2^32, rounded half away
    // ------------------------------------------------------------------
    logic signed [15:0] u0;
    logic [15:0]        b0;
    logic [14:0]        umag0;
    logic [28:0]        p0;
    logic [25:0]        d0;
    logic [61:0]        num0;
    logic [3:0]         e0;
    fstage_t            fs0;

    always_comb begin
        if (fahr_reg) begin
            u0 = 16'(s_temperature_centi) - 16'sd3200;
            b0 = 16'(17'sd40162 + 17'(s_temperature_centi));
        end else begin
            u0 = 16'(s_temperature_centi);
            b0 = 16'(17'sd24090 + 17'(s_temperature_centi));
        end
        umag0 = u0[15] ? 15'(-u0) : u0[14:0];
        p0    = 29'(umag0 * 15'd17502);
        d0    = 26'(b0 * 10'd1000);
        num0  = {1'b0, p0, 32'd0} + 62'(d0 >> 1);
        // leading one of the humidity
        e0 = 4'd0;
        for (int i = 1; i < 14; i++) begin
            if (s_humidity_centi[i]) e0 = 4'(i);
        end
        fs0.hzero = (s_humidity_centi == 14'd0);
        fs0.neg1  = u0[15];
        fs0.d1    = d0;
        fs0.r1    = 26'(num0[61:38]);
        fs0.nq1   = num0[37:0];
        fs0.ex    = e0;
        fs0.m     = 31'({s_humidity_centi, 17'd0} << (4'd13 - e0));
        fs0.frac  = 32'd0;
    end

    fstage_t fs_reg     [0:DIV1_STEPS];
    logic    fs_vld_reg [0:DIV1_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_vld_reg[0] <= 1'b0;
        end else if (en) begin
            fs_vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fs_reg[0] <= fs0;
        end
    end

    // ------------------------------------------------------------------
    // stages 1..38: one quotient bit each; the first 32 also square the
    // log mantissa (Q30) and shift out one fraction bit
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= DIV1_STEPS; k++) begin : g_front
        fstage_t     cur;
        fstage_t     nxt;
        logic [26:0] trial;
        logic [61:0] sq;

        always_comb begin
            cur   = fs_reg[k-1];
            nxt   = cur;
            trial = {cur.r1, cur.nq1[37]};
            if (trial >= {1'b0, cur.d1}) begin
                nxt.r1  = 26'(trial - {1'b0, cur.d1});
                nxt.nq1 = {cur.nq1[36:0], 1'b1};
            end else begin
                nxt.r1  = trial[25:0];
                nxt.nq1 = {cur.nq1[36:0], 1'b0};
            end
            sq = {31'd0, cur.m} * {31'd0, cur.m};
            if (k <= LOG_STEPS) begin
                nxt.m    = sq[61] ? sq[61:31] : sq[60:30];
                nxt.frac = {cur.frac[30:0], sq[61]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fs_vld_reg[k] <= 1'b0;
            end else if (en) begin
                fs_vld_reg[k] <= fs_vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                fs_reg[k] <= nxt;
            end
        end
    end

    fstage_t fl;
    assign fl = fs_reg[DIV1_STEPS];

    // ------------------------------------------------------------------
    // stage A: sign the Magnus term, fraction times ln2
    // ------------------------------------------------------------------
    logic                a_vld_reg;
    logic                a_hzero_reg;
    logic [3:0]          a_ex_reg;
    logic signed [39:0]  a_xq_reg;
    logic [63:0]         a_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= fs_vld_reg[DIV1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_hzero_reg <= fl.hzero;
            a_ex_reg    <= fl.ex;
            a_xq_reg    <= fl.neg1 ? -$signed({2'b00, fl.nq1}) : $signed({2'b00, fl.nq1});
            a_prod_reg  <= {32'd0, fl.frac} * {32'd0, LN2_Q32};
        end
    end

    // ------------------------------------------------------------------
    // stage B: L = ln(hc) - ln(10000) + x, den = 17.5 - L (all Q32)
    // ------------------------------------------------------------------
    logic [35:0]         b_eln;
    logic signed [41:0]  b_lq_next;
    logic                b_vld_reg;
    logic                b_hzero_reg;
    logic signed [41:0]  b_lq_reg;
    logic signed [42:0]  b_den_reg;

    always_comb begin
        b_eln     = 36'(a_ex_reg * LN2_Q32);
        b_lq_next = $signed({6'd0, b_eln}) + $signed({10'd0, a_prod_reg[63:32]})
                  - $signed(42'(LN_10000)) + 42'(a_xq_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_hzero_reg <= a_hzero_reg;
            b_lq_reg    <= b_lq_next;
            b_den_reg   <= DEN_BASE - 43'(b_lq_next);
        end
    end

    // ------------------------------------------------------------------
    // stage C: |L| * 24090
    // ------------------------------------------------------------------
    logic [40:0]  c_lmag;
    logic         c_vld_reg;
    logic         c_hzero_reg;
    logic         c_ok_reg;
    logic         c_neg_reg;
    logic [55:0]  c_nmag_reg;
    logic [41:0]  c_den_reg;

    assign c_lmag = b_lq_reg[41] ? 41'(-b_lq_reg) : b_lq_reg[40:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_hzero_reg <= b_hzero_reg;
            c_ok_reg    <= !b_den_reg[42] && (b_den_reg != 43'sd0);
            c_neg_reg   <= b_lq_reg[41];
            c_nmag_reg  <= c_lmag * 15'd24090;
            c_den_reg   <= b_den_reg[41:0];
        end
    end

    // ------------------------------------------------------------------
    // stage D and 16 divide stages: rounded 24090*L / den; the output saturates a quotient that reaches 2^15
    // ------------------------------------------------------------------
    logic [56:0] d_num;
    bstage_t     bs0;

    always_comb begin
        d_num     = {1'b0, c_nmag_reg} + 57'(c_den_reg >> 1);
        bs0.hzero = c_hzero_reg;
        bs0.ok    = c_ok_reg;
        bs0.neg2  = c_neg_reg;
        bs0.d2    = c_den_reg;
        bs0.r2    = d_num[56:16] == 41'd0 ? 42'd0 : {1'b0, d_num[56:16]};
        bs0.nq2   = d_num[15:0];
    end

    bstage_t bs_reg     [0:DIV2_STEPS];
    logic    bs_vld_reg [0:DIV2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_vld_reg[0] <= 1'b0;
        end else if (en) begin
            bs_vld_reg[0] <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bs_reg[0] <= bs0;
        end
    end

    for (genvar k = 1; k <= DIV2_STEPS; k++) begin : g_back
        bstage_t     cur;
        bstage_t     nxt;
        logic [42:0] trial;

        always_comb begin
            cur   = bs_reg[k-1];
            nxt   = cur;
            trial = {cur.r2, cur.nq2[15]};
            if (trial >= {1'b0, cur.d2}) begin
                nxt.r2  = 42'(trial - {1'b0, cur.d2});
                nxt.nq2 = {cur.nq2[14:0], 1'b1};
            end else begin
                nxt.r2  = trial[41:0];
                nxt.nq2 = {cur.nq2[14:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                bs_vld_reg[k] <= 1'b0;
            end else if (en) begin
                bs_vld_reg[k] <= bs_vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                bs_reg[k] <= nxt;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: sign, clamp, sentinel
    // ------------------------------------------------------------------
    bstage_t            bl;
    logic signed [15:0] dew_next;
    logic               dvalid_next;
    logic signed [15:0] dew_reg;
    logic               dvalid_reg;

    assign bl = bs_reg[DIV2_STEPS];

    always_comb begin
        dvalid_next = 1'b1;
        if (bl.hzero || !bl.ok) begin
            dew_next    = SENTINEL_CENTI;
            dvalid_next = 1'b0;
        end else if (bl.neg2) begin
            dew_next = (bl.nq2 > 16'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, bl.nq2}));
        end else begin
            dew_next = (bl.nq2 > 16'd32767) ? 16'sd32767 : $signed(bl.nq2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= bs_vld_reg[DIV2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dew_reg    <= dew_next;
            dvalid_reg <= dvalid_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_dew_point_centi = dew_reg;
    assign m_dew_point_valid = dvalid_reg;

endmodule
`default_nettype wire

>>> hdl/dpm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_checker
// Port-level checks on the dew point block, bound to the top level.
// ----------------------------------------------------------------------------
module dpm_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [2:0]         paddr,
    input wire logic [31:0]        pwdata,
    input wire logic [31:0]        prdata,
    input wire logic               pready,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [13:0]        s_humidity_centi,
    input wire logic signed [14:0] s_temperature_centi,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_dew_point_centi,
    input wire logic               m_dew_point_valid
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dew_point_centi)
                                && $stable(m_dew_point_valid))
        else $error("result beat changed while stalled");

    // input side only backs up behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // invalid result carries the sentinel
    a_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dew_point_valid |-> m_dew_point_centi == -16'sd27300)
        else $error("invalid result without sentinel");

    // unit select reads back what was written
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr[2] == 1'b0
        |=> paddr[2] != 1'b0 || prdata[0] == $past(pwdata[0]))
        else $error("unit select readback mismatch");

endmodule

bind dew_point_magnus dpm_checker u_dpm_checker (.*);
`default_nettype wire
